>>> sv/sbdasc_pkg.sv
// Shared types, character codes and decimal weight table for the itoa unit.
`timescale 1ns / 1ps

package sbdasc_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam int unsigned MAG_W  = 32;
  localparam int unsigned WGT_W  = 34;   // holds 9 * 10^9
  localparam int unsigned POS_W  = 4;
  localparam logic [POS_W-1:0] TOP_POS = 4'd9;

  // Word handed from the front to the back: sign and unsigned magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sbdasc_item_t;

  function automatic logic [WGT_W-1:0] pow_ten(input logic [POS_W-1:0] pos);
    logic [WGT_W-1:0] p;
    unique case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

>>> sv/sbdasc_front.sv
// Input stage: takes a word, splits it into sign and magnitude, hands it to the queue.
`timescale 1ns / 1ps

module sbdasc_front import sbdasc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] in_value,
  output logic               q_push,
  input  logic               q_full,
  output sbdasc_item_t       q_item
);

  logic         vld_r, vld_nxt;
  sbdasc_item_t item_r, item_nxt;
  logic [MAG_W-1:0] raw;
  logic         accept;

  assign full   = vld_r && q_full;
  assign accept = push && !full;
  assign q_push = vld_r && !q_full;
  assign q_item = item_r;

  always_comb begin
    raw          = MAG_W'(in_value);
    item_nxt.neg = raw[MAG_W-1];
    // unsigned negate: the most negative value maps to 2^31 correctly
    item_nxt.mag = raw[MAG_W-1] ? (~raw + 32'd1) : raw;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> sv/sbdasc_fifo.sv
// Two-entry queue between the front and the digit engine.
`timescale 1ns / 1ps

module sbdasc_fifo import sbdasc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  sbdasc_item_t wr_item,
  output logic         wr_full,
  input  logic         rd_en,
  output logic         rd_empty,
  output sbdasc_item_t rd_item
);

  sbdasc_item_t mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r, cnt_nxt;

  assign wr_full  = (cnt_r == 2'd2);
  assign rd_empty = (cnt_r == 2'd0);
  assign rd_item  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> sv/sbdasc_back.sv
// Digit engine: emits sign then decimal digits to an output register, word by word.
`timescale 1ns / 1ps

module sbdasc_back import sbdasc_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  sbdasc_item_t q_item,
  output logic         q_pop,
  input  logic         pop,
  output logic         empty,
  output logic [7:0]   out_character,
  output logic         out_last
);

  localparam int ND = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 19) ? 19 : MAX_DIGITS);
  localparam logic [4:0] ND_LIM = 5'(ND);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             started_r, started_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic             load_out;

  logic             slot_free;
  logic [WGT_W-1:0] weight [1:9];
  logic [WGT_W-1:0] sub;
  logic [3:0]       digit;
  logic             emit_dig;

  assign empty         = !out_vld_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign slot_free     = !out_vld_r || pop;

  // digit = largest k with k * 10^pos <= magnitude
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      weight[k] = pow_ten(pos_r) * WGT_W'(k);
      if ({2'b00, mag_r} >= weight[k]) begin
        digit = 4'(k);
        sub   = weight[k];
      end
    end
    // positions at or above the digit limit are consumed but not shown
    emit_dig = ({1'b0, pos_r} < ND_LIM) &&
               (started_r || (digit != 4'd0) || (pos_r == '0));
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    q_pop       = 1'b0;
    load_out    = 1'b0;
    char_nxt    = char_r;
    last_nxt    = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          mag_nxt     = q_item.mag;
          pos_nxt     = TOP_POS;
          started_nxt = 1'b0;
          state_nxt   = q_item.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          load_out  = 1'b1;
          char_nxt  = CHAR_MINUS;
          last_nxt  = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          mag_nxt = 32'({2'b00, mag_r} - sub);
          if (emit_dig) begin
            load_out    = 1'b1;
            started_nxt = 1'b1;
            char_nxt    = CHAR_ZERO + {4'd0, digit};
            last_nxt    = (pos_r == '0);
          end
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_vld_nxt = load_out || (out_vld_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    pos_r     <= pos_nxt;
    started_r <= started_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

endmodule

>>> sv/signed_binary_to_decimal_ascii_unit.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per word.
//
//   channel   direction  handshake            payload
//   input     in         push / full          in_value[31:0] (signed)
//   result    out        empty / pop          out_character[7:0], out_last
//
// A word is registered by the front stage, parked in a two-entry queue, then
// expanded by the digit engine. The engine loads a word from the queue, emits
// the minus sign when negative, and always scans the decimal positions 10^9
// down to 10^0 (one compare-and-subtract per cycle while the output register
// can take a character); it takes the next word only after position 10^0 and
// stalls while the result side holds pop low with the output register full.
// Leading zeros and positions at or above MAX_DIGITS (clamped to 1..19) are
// scanned but not shown. Synchronous reset clears the front valid, queue
// pointers, engine state and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit import sbdasc_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] in_value,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_character,
  output logic               out_last
);

  // front -> queue
  logic         fq_push;
  logic         fq_full;
  sbdasc_item_t fq_item;

  // queue -> digit engine
  logic         qb_pop;
  logic         qb_empty;
  sbdasc_item_t qb_item;

  sbdasc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .q_push   (fq_push),
    .q_full   (fq_full),
    .q_item   (fq_item)
  );

  sbdasc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fq_push),
    .wr_item  (fq_item),
    .wr_full  (fq_full),
    .rd_en    (qb_pop),
    .rd_empty (qb_empty),
    .rd_item  (qb_item)
  );

  sbdasc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (qb_empty),
    .q_item        (qb_item),
    .q_pop         (qb_pop),
    .pop           (pop),
    .empty         (empty),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // only a minus sign or a decimal digit ever reaches the result port
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_character == CHAR_MINUS) ||
               ((out_character >= CHAR_ZERO) && (out_character <= CHAR_NINE)))
    else $error("illegal character on result port");

  // a sign is always followed by at least one digit
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_character == CHAR_MINUS)) |-> !out_last)
    else $error("minus sign flagged as last");

  // reset leaves both sides open and nothing pending
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("block not clean after reset");

  // the engine never pulls from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qb_pop |-> !qb_empty)
    else $error("queue read while empty");

endmodule
